>>> rtl/fqs_pkg.sv
`default_nettype none

package fqs_pkg;

    // Word and field widths of the item
    localparam int DATA_W = 32;
    localparam int POS_W  = 4;
    localparam int OP_W   = 2;

    // Operation codes carried in s_tuser
    localparam logic [OP_W-1:0] OP_PUSH   = 2'd0;
    localparam logic [OP_W-1:0] OP_POP    = 2'd1;
    localparam logic [OP_W-1:0] OP_PEEK   = 2'd2;
    localparam logic [OP_W-1:0] OP_SEARCH = 2'd3;

    // Word returned by pop or peek on an empty queue
    localparam logic signed [DATA_W-1:0] EMPTY_WORD = -32'sd1;

    // Result item as packed into m_tdata, lowest field last
    typedef struct packed {
        logic                     pad;
        logic                     queue_full;
        logic                     queue_empty;
        logic                     success;
        logic [POS_W-1:0]         position_out;
        logic signed [DATA_W-1:0] data_out;
    } result_t;

endpackage

`default_nettype wire

>>> rtl/fqs_ram.sv
`default_nettype none

module fqs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write one word, read one word with registered output
    always_ff @(posedge clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire

>>> rtl/fifo_queue_with_search.sv
`default_nettype none
// Steps: push goes IDLE, DONE; pop and peek go IDLE, RD, DONE; search goes IDLE,
// SCAN, DONE, scanning from the head to a match or the tail; on an empty queue pop,
// peek and search go IDLE, DONE. Throughput: one item at a time, so an item holds
// the block until its result is loaded into the output register, and the next item
// is taken only after that. The single RAM read port scans one entry a cycle.
// Reset: head, tail and count clear at once; stored words are kept, no clearing pass.

module fifo_queue_with_search #(
    parameter int DEPTH = 16
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    // s_tdata: push_value [31:0], search_key [63:32]
    input  wire logic [63:0]                    s_tdata,
    // s_tuser: opcode [1:0]
    input  wire logic [fqs_pkg::OP_W-1:0]       s_tuser,
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    // m_tdata: data_out [31:0], position_out [35:32], success [36],
    //          queue_empty [37], queue_full [38], zero [39]
    output logic [$bits(fqs_pkg::result_t)-1:0] m_tdata,
    output logic                                m_tvalid,
    input  wire logic                           m_tready
);

    import fqs_pkg::*;

    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_RD   = 2'd1;
    localparam logic [1:0] ST_SCAN = 2'd2;
    localparam logic [1:0] ST_DONE = 2'd3;

    logic [1:0]               state_reg, state_next;
    logic [IDX_W-1:0]         head_reg, head_next;
    logic [IDX_W-1:0]         tail_reg, tail_next;
    logic [CNT_W-1:0]         count_reg, count_next;
    logic [IDX_W-1:0]         scan_ptr_reg, scan_ptr_next;
    logic [IDX_W-1:0]         dist_reg, dist_next;
    logic signed [DATA_W-1:0] key_reg, key_next;
    logic [OP_W-1:0]          op_reg, op_next;
    logic signed [DATA_W-1:0] res_data_reg, res_data_next;
    logic [POS_W-1:0]         res_pos_reg, res_pos_next;
    logic                     res_ok_reg, res_ok_next;
    logic                     m_tvalid_reg, m_tvalid_next;
    result_t                  m_tdata_reg, m_tdata_next;

    logic                     wr_en;
    logic [IDX_W-1:0]         rd_addr;
    logic [DATA_W-1:0]        rd_data;
    logic                     q_empty;
    logic                     q_full;
    logic [OP_W-1:0]          in_op;
    logic signed [DATA_W-1:0] in_value;
    logic signed [DATA_W-1:0] in_key;

    function automatic logic [IDX_W-1:0] ring_next(input logic [IDX_W-1:0] idx);
        return (idx == LAST_IDX) ? '0 : idx + 1'b1;
    endfunction

    assign in_op    = s_tuser;
    assign in_value = s_tdata[DATA_W-1:0];
    assign in_key   = s_tdata[2*DATA_W-1:DATA_W];
    assign q_empty  = (count_reg == '0);
    assign q_full   = (count_reg == FULL_CNT);
    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // Read at the head when idle, at the scan pointer while searching
    assign rd_addr = (state_reg == ST_SCAN) ? scan_ptr_reg : head_reg;

    fqs_ram #(
        .WIDTH(DATA_W),
        .DEPTH(DEPTH)
    ) u_store (
        .clk    (aclk),
        .wr_en  (wr_en),
        .wr_addr(tail_reg),
        .wr_data(in_value),
        .rd_addr(rd_addr),
        .rd_data(rd_data)
    );

    // Sequencer: decode, read, scan one entry a cycle, hand over the result
    always_comb begin
        state_next    = state_reg;
        head_next     = head_reg;
        tail_next     = tail_reg;
        count_next    = count_reg;
        scan_ptr_next = scan_ptr_reg;
        dist_next     = dist_reg;
        key_next      = key_reg;
        op_next       = op_reg;
        res_data_next = res_data_reg;
        res_pos_next  = res_pos_reg;
        res_ok_next   = res_ok_reg;
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        wr_en         = 1'b0;

        // Drop the result once it is taken
        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    op_next       = in_op;
                    key_next      = in_key;
                    res_data_next = '0;
                    res_pos_next  = '0;
                    res_ok_next   = 1'b0;
                    state_next    = ST_DONE;
                    unique case (in_op) inside
                        OP_PUSH: begin
                            if (!q_full) begin
                                wr_en       = 1'b1;
                                tail_next   = ring_next(tail_reg);
                                count_next  = count_reg + 1'b1;
                                res_ok_next = 1'b1;
                            end
                        end
                        OP_POP, OP_PEEK: begin
                            if (q_empty) begin
                                res_data_next = EMPTY_WORD;
                            end else begin
                                state_next = ST_RD;
                            end
                        end
                        OP_SEARCH: begin
                            if (!q_empty) begin
                                scan_ptr_next = ring_next(head_reg);
                                dist_next     = '0;
                                state_next    = ST_SCAN;
                            end
                        end
                        default: begin
                            state_next = ST_DONE;
                        end
                    endcase
                end
            end
            ST_RD: begin
                res_data_next = rd_data;
                res_ok_next   = 1'b1;
                if (op_reg == OP_POP) begin
                    head_next  = ring_next(head_reg);
                    count_next = count_reg - 1'b1;
                end
                state_next = ST_DONE;
            end
            ST_SCAN: begin
                // Compare the entry read last cycle, fetch the one after
                if (rd_data == key_reg) begin
                    res_ok_next  = 1'b1;
                    res_pos_next = POS_W'(dist_reg);
                    state_next   = ST_DONE;
                end else if (CNT_W'(dist_reg) + 1'b1 == count_reg) begin
                    state_next = ST_DONE;
                end else begin
                    scan_ptr_next = ring_next(scan_ptr_reg);
                    dist_next     = dist_reg + 1'b1;
                end
            end
            ST_DONE: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next             = 1'b1;
                    m_tdata_next.pad          = 1'b0;
                    m_tdata_next.queue_full   = q_full;
                    m_tdata_next.queue_empty  = q_empty;
                    m_tdata_next.success      = res_ok_reg;
                    m_tdata_next.position_out = res_pos_reg;
                    m_tdata_next.data_out     = res_data_reg;
                    state_next                = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            head_reg     <= '0;
            tail_reg     <= '0;
            count_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            head_reg     <= head_next;
            tail_reg     <= tail_next;
            count_reg    <= count_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // Payload and scan registers
    always_ff @(posedge aclk) begin
        scan_ptr_reg <= scan_ptr_next;
        dist_reg     <= dist_next;
        key_reg      <= key_next;
        op_reg       <= op_next;
        res_data_reg <= res_data_next;
        res_pos_reg  <= res_pos_next;
        res_ok_reg   <= res_ok_next;
        m_tdata_reg  <= m_tdata_next;
    end

    // Checks
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= FULL_CNT)
        else $error("entry count above depth");

    a_ring_ends: assert property (@(posedge aclk) disable iff (!aresetn)
        (count_reg == '0 || count_reg == FULL_CNT) |-> head_reg == tail_reg)
        else $error("head and tail disagree with count");

    a_scan_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SCAN || state_reg == ST_RD) |-> count_reg != '0)
        else $error("store read on an empty queue");

    a_scan_stops: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_SCAN |-> CNT_W'(dist_reg) < count_reg)
        else $error("scan ran past the tail");

endmodule

`default_nettype wire

>>> dv/fqs_checker.sv
// Watch both channels, keep a shadow of the queue and compare every result item.
module fqs_checker
    import fqs_pkg::*;
#(
    parameter int DEPTH = 16
) (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic [63:0]            s_tdata,
    input  wire logic [OP_W-1:0]        s_tuser,
    input  wire logic                   s_tvalid,
    input  wire logic                   s_tready,
    input  wire logic [$bits(result_t)-1:0] m_tdata,
    input  wire logic                   m_tvalid,
    input  wire logic                   m_tready,
    output int                          fail_count,
    output int                          outstanding,
    output int                          search_hits,
    output int                          push_drops
);

    // Shadow of the ring and its pointers
    logic signed [DATA_W-1:0] shadow_ring [DEPTH];
    int                       shadow_head;
    int                       shadow_tail;
    int                       shadow_fill;

    // Results owed by the block, oldest first
    result_t                  answers_due [$];

    // Apply one operation to the shadow queue and return the result it owes
    function automatic result_t queue_answer(logic [OP_W-1:0] op,
                                             logic signed [DATA_W-1:0] word,
                                             logic signed [DATA_W-1:0] key);
        result_t ans;
        int      idx;
        int      step;
        logic    found;
        ans   = '0;
        found = 1'b0;
        case (op)
            OP_PUSH: begin
                if (shadow_fill < DEPTH) begin
                    shadow_ring[shadow_tail] = word;
                    shadow_tail = (shadow_tail + 1) % DEPTH;
                    shadow_fill++;
                    ans.success = 1'b1;
                end
            end
            OP_POP, OP_PEEK: begin
                if (shadow_fill == 0) begin
                    ans.data_out = EMPTY_WORD;
                end else begin
                    ans.data_out = shadow_ring[shadow_head];
                    ans.success  = 1'b1;
                    if (op == OP_POP) begin
                        shadow_head = (shadow_head + 1) % DEPTH;
                        shadow_fill--;
                    end
                end
            end
            OP_SEARCH: begin
                // Walk from the head; the first equal word wins
                idx = shadow_head;
                for (step = 0; step < shadow_fill; step++) begin
                    if (!found && shadow_ring[idx] == key) begin
                        found            = 1'b1;
                        ans.success      = 1'b1;
                        ans.position_out = step[POS_W-1:0];
                    end
                    idx = (idx + 1) % DEPTH;
                end
            end
        endcase
        ans.queue_empty = (shadow_fill == 0);
        ans.queue_full  = (shadow_fill >= DEPTH);
        return ans;
    endfunction

    // Report one field that differs
    task automatic check_field(string name, longint want, longint got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endtask

    // Pop the owed result on each output item, push a new one on each input item
    always @(posedge aclk) begin : watch
        result_t got;
        result_t want;
        result_t fresh;
        if (!aresetn) begin
            shadow_head = 0;
            shadow_tail = 0;
            shadow_fill = 0;
            answers_due.delete();
            fail_count  = 0;
            search_hits = 0;
            push_drops  = 0;
            outstanding <= 0;
        end else begin
            if (m_tvalid && m_tready) begin
                got = result_t'(m_tdata);
                if (answers_due.size() == 0) begin
                    $error("result item %h arrived with none owed", m_tdata);
                    fail_count++;
                end else begin
                    want = answers_due.pop_front();
                    check_field("data_out", want.data_out, got.data_out);
                    check_field("position_out", want.position_out, got.position_out);
                    check_field("success", want.success, got.success);
                    check_field("queue_empty", want.queue_empty, got.queue_empty);
                    check_field("queue_full", want.queue_full, got.queue_full);
                end
            end
            if (s_tvalid && s_tready) begin
                fresh = queue_answer(s_tuser, s_tdata[31:0], s_tdata[63:32]);
                if (s_tuser == OP_SEARCH && fresh.success)
                    search_hits++;
                if (s_tuser == OP_PUSH && !fresh.success)
                    push_drops++;
                answers_due.push_back(fresh);
            end
            outstanding <= answers_due.size();
        end
    end

endmodule

>>> dv/tb_fifo_queue_with_search.sv
// Drive the queue with directed and random operations; the checker judges results.
module tb_fifo_queue_with_search;
    import fqs_pkg::*;

    localparam int DEPTH        = 16;
    localparam int PHASE_ITEMS  = 225;
    localparam int HOLD_CYCLES  = 200;
    localparam int SETTLE       = 40;

    logic                        aclk     = 1'b0;
    logic                        aresetn  = 1'b0;
    logic [63:0]                 s_tdata  = '0;
    logic [OP_W-1:0]             s_tuser  = OP_PUSH;
    logic                        s_tvalid = 1'b0;
    logic                        s_tready;
    logic [$bits(result_t)-1:0]  m_tdata;
    logic                        m_tvalid;
    logic                        m_tready = 1'b0;

    int fail_count;
    int outstanding;
    int search_hits;
    int push_drops;

    // Idle chances in percent, and the long receiver hold-off
    int tx_idle    = 0;
    int rx_idle    = 0;
    int hold_seq   = 0;
    int hold_seen  = 0;
    int hold_left  = 0;

    // Offered operations per opcode, and recent pushed words for search keys
    int                       offered [4] = '{0, 0, 0, 0};
    logic signed [DATA_W-1:0] recent_words [DEPTH];
    int                       recent_wr = 0;

    always #2 aclk = ~aclk;

    fifo_queue_with_search #(.DEPTH(DEPTH)) u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tdata  (m_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready)
    );

    fqs_checker #(.DEPTH(DEPTH)) u_checker (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .m_tdata     (m_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .fail_count  (fail_count),
        .outstanding (outstanding),
        .search_hits (search_hits),
        .push_drops  (push_drops)
    );

    // Receiver: random back-pressure, or a long hold-off when one is requested
    always @(posedge aclk) begin
        if (hold_left > 0) begin
            m_tready  <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (hold_seq != hold_seen) begin
            hold_seen <= hold_seq;
            hold_left <= HOLD_CYCLES;
            m_tready  <= 1'b0;
        end else begin
            m_tready  <= ($urandom_range(0, 99) >= rx_idle);
        end
    end

    // Offer one item, with a random gap first, and hold until it is taken
    task automatic send_item(logic [OP_W-1:0] op, logic signed [DATA_W-1:0] word,
                             logic signed [DATA_W-1:0] key);
        if (tx_idle > 0 && $urandom_range(0, 99) < tx_idle) begin
            s_tvalid <= 1'b0;
            do
                @(posedge aclk);
            while ($urandom_range(0, 99) < tx_idle);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {key, word};
        offered[op]++;
        if (op == OP_PUSH) begin
            recent_words[recent_wr] = word;
            recent_wr = (recent_wr + 1) % DEPTH;
        end
        do
            @(posedge aclk);
        while (!s_tready);
    endtask

    // Stop offering until every owed result has come back
    task automatic wait_quiet();
        s_tvalid <= 1'b0;
        do
            @(posedge aclk);
        while (outstanding != 0);
    endtask

    // Small words repeat often, so searches see duplicates
    function automatic logic signed [DATA_W-1:0] pick_word();
        if ($urandom_range(0, 2) == 0)
            return $urandom_range(0, 7);
        return $urandom();
    endfunction

    // Random operations; the mix drifts between filling, draining and balance
    task automatic random_items(int count);
        int n;
        int mix;
        int roll;
        logic [OP_W-1:0] op;
        logic signed [DATA_W-1:0] key;
        mix = 0;
        for (n = 0; n < count; n++) begin
            if (n % 40 == 0)
                mix = $urandom_range(0, 2);
            roll = $urandom_range(0, 99);
            case (mix)
                0: op = (roll < 55) ? OP_PUSH : (roll < 75) ? OP_POP :
                        (roll < 85) ? OP_PEEK : OP_SEARCH;
                1: op = (roll < 20) ? OP_PUSH : (roll < 70) ? OP_POP :
                        (roll < 80) ? OP_PEEK : OP_SEARCH;
                default: op = (roll < 30) ? OP_PUSH : (roll < 60) ? OP_POP :
                              (roll < 75) ? OP_PEEK : OP_SEARCH;
            endcase
            if ($urandom_range(0, 9) < 7)
                key = recent_words[$urandom_range(0, DEPTH - 1)];
            else
                key = pick_word();
            send_item(op, pick_word(), key);
        end
    endtask

    initial begin : stimulus
        int i;
        logic signed [DATA_W-1:0] word;
        for (i = 0; i < DEPTH; i++)
            recent_words[i] = '0;

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        tx_idle = 33;
        rx_idle <= 51;
        @(posedge aclk);

        // Empty queue: pop, peek and search all fail
        send_item(OP_POP, $urandom(), $urandom());
        send_item(OP_PEEK, $urandom(), $urandom());
        send_item(OP_SEARCH, $urandom(), 32'sd0);

        // Fill to the brim: extremes first, a repeated word, a marker at the tail
        for (i = 0; i < DEPTH; i++) begin
            case (i)
                0:       word = 32'sh8000_0000;
                1:       word = 32'sh7FFF_FFFF;
                2:       word = 32'sd0;
                3:       word = -32'sd1;
                15:      word = 32'sh5A5A_A5A5;
                default: word = (i % 4 == 0) ? 32'sd7 : $urandom();
            endcase
            send_item(OP_PUSH, word, $urandom());
        end

        // Push on a full queue is dropped
        send_item(OP_PUSH, 32'sd123, $urandom());
        // Match at the far end, first of several matches, and a miss
        send_item(OP_SEARCH, $urandom(), 32'sh5A5A_A5A5);
        send_item(OP_SEARCH, $urandom(), 32'sd7);
        send_item(OP_SEARCH, $urandom(), 32'sh1234_5678);
        send_item(OP_PEEK, $urandom(), $urandom());
        send_item(OP_POP, $urandom(), $urandom());

        // Long receiver hold-off while items keep coming
        hold_seq <= hold_seq + 1;
        random_items(PHASE_ITEMS);
        wait_quiet();

        tx_idle = 51;
        rx_idle <= 33;
        random_items(PHASE_ITEMS);
        wait_quiet();

        tx_idle = 0;
        rx_idle <= 0;
        random_items(PHASE_ITEMS);

        wait_quiet();
        repeat (SETTLE) @(posedge aclk);

        $display("tb: offered %0d push, %0d pop, %0d peek and %0d search items",
                 offered[OP_PUSH], offered[OP_POP], offered[OP_PEEK], offered[OP_SEARCH]);
        $display("tb: %0d pushes dropped on a full queue, %0d searches found their key",
                 push_drops, search_hits);
        if (fail_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    // Watchdog
    initial begin
        #2_000_000;
        $display("tb: failure");
        $finish;
    end

endmodule
